/* rtl/dtt_pkg.sv */
// ----------------------------------------------------------------------------
// dtt_pkg: shared types and constants of the description text tokenizer
// Character codes, token kinds, error codes and the result word format.
// ----------------------------------------------------------------------------
package dtt_pkg;

	localparam int CHAR_W = 8;
	localparam int KIND_W = 4;
	localparam int OFFS_W = 16;
	localparam int ERR_W  = 2;

	localparam logic [CHAR_W-1:0] CH_LBRACE = 8'h7B;
	localparam logic [CHAR_W-1:0] CH_RBRACE = 8'h7D;
	localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
	localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
	localparam logic [CHAR_W-1:0] CH_UNDER  = 8'h5F;
	localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;
	localparam logic [CHAR_W-1:0] CH_LOW_E  = 8'h65;
	localparam logic [CHAR_W-1:0] CH_UP_E   = 8'h45;
	localparam logic [CHAR_W-1:0] CH_SEMI   = 8'h3B;
	localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2C;
	localparam logic [CHAR_W-1:0] CH_EQUALS = 8'h3D;
	localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
	localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_QUOTE  = 8'h22;
	localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
	localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
	localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_DIG_0  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_DIG_9  = 8'h39;
	localparam logic [CHAR_W-1:0] CH_UP_A   = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UP_Z   = 8'h5A;
	localparam logic [CHAR_W-1:0] CH_LOW_A  = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LOW_Z  = 8'h7A;

	typedef enum logic [KIND_W-1:0] {
		TK_EOS    = 4'd0,
		TK_LBRACE = 4'd1,
		TK_RBRACE = 4'd2,
		TK_LPAREN = 4'd3,
		TK_RPAREN = 4'd4,
		TK_WORD   = 4'd5,
		TK_NUMBER = 4'd6,
		TK_STRING = 4'd7,
		TK_SEMI   = 4'd8,
		TK_COMMA  = 4'd9,
		TK_EQUALS = 4'd10,
		TK_SLASH  = 4'd11
	} tok_kind_t;

	typedef enum logic [ERR_W-1:0] {
		ER_NONE     = 2'd0,
		ER_EOL_STR  = 2'd1,
		ER_EOT_STR  = 2'd2,
		ER_UNKNOWN  = 2'd3
	} tok_err_t;

	typedef struct packed {
		tok_kind_t           kind;
		logic [OFFS_W-1:0]   start;
		logic [OFFS_W-1:0]   length;
		tok_err_t            error;
		logic                last;
	} dtt_result_t;

	// Results produced by one character: up to two, in order.
	typedef struct packed {
		logic [1:0]  count;
		dtt_result_t first;
		dtt_result_t second;
	} dtt_push_t;

	function automatic logic is_digit(input logic [CHAR_W-1:0] c);
		return (c >= CH_DIG_0) && (c <= CH_DIG_9);
	endfunction

	function automatic logic is_letter(input logic [CHAR_W-1:0] c);
		return ((c >= CH_LOW_A) && (c <= CH_LOW_Z)) || ((c >= CH_UP_A) && (c <= CH_UP_Z));
	endfunction

	function automatic logic is_space(input logic [CHAR_W-1:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
	endfunction

	// Kind of a single-character token, or TK_EOS when the character is none.
	function automatic tok_kind_t punct_kind(input logic [CHAR_W-1:0] c);
		tok_kind_t k;
		case (c)
			CH_LBRACE: k = TK_LBRACE;
			CH_RBRACE: k = TK_RBRACE;
			CH_LPAREN: k = TK_LPAREN;
			CH_RPAREN: k = TK_RPAREN;
			CH_SEMI:   k = TK_SEMI;
			CH_COMMA:  k = TK_COMMA;
			CH_EQUALS: k = TK_EQUALS;
			CH_SLASH:  k = TK_SLASH;
			default:   k = TK_EOS;
		endcase
		return k;
	endfunction

endpackage

/* rtl/dtt_ifs.sv */
// ----------------------------------------------------------------------------
// dtt_ifs: channel interfaces of the description text tokenizer
// Character channel in, token channel out, both valid/ready.
// ----------------------------------------------------------------------------
interface dtt_char_if
	import dtt_pkg::*;
	;
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] char_code;
	logic              end_of_text;

	modport source (output valid, char_code, end_of_text, input ready);
	modport sink   (input valid, char_code, end_of_text, output ready);
endinterface

interface dtt_token_if
	import dtt_pkg::*;
	;
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] token_kind;
	logic [OFFS_W-1:0] token_start;
	logic [OFFS_W-1:0] token_length;
	logic [ERR_W-1:0]  error_code;
	logic              last;

	modport source (output valid, token_kind, token_start, token_length, error_code, last,
		input ready);
	modport sink   (input valid, token_kind, token_start, token_length, error_code, last,
		output ready);
endinterface

/* rtl/dtt_scan.sv */
// ----------------------------------------------------------------------------
// dtt_scan: character register and scanner state machine
// Registers one character word, then classifies it against the scan state and
// produces up to two result words for the queue behind it.
// ----------------------------------------------------------------------------
module dtt_scan
	import dtt_pkg::*;
#(
	parameter int MAX_TEXT = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	dtt_char_if.sink    chars,
	input  logic        room,
	output dtt_push_t   push
);

	localparam int POS_MAX = (MAX_TEXT - 1 < 65535) ? MAX_TEXT - 1 : 65535;
	localparam int POS_W   = $clog2(POS_MAX + 1);

	typedef enum logic [6:0] {
		PH_IDLE = 7'b0000001,
		PH_WORD = 7'b0000010,
		PH_INT  = 7'b0000100,
		PH_FRAC = 7'b0001000,
		PH_EXPS = 7'b0010000,
		PH_EXPD = 7'b0100000,
		PH_STR  = 7'b1000000
	} phase_t;

	logic              valid_s1;
	logic [CHAR_W-1:0] char_s1;
	logic              eot_s1;

	phase_t            phase_q, phase_n;
	logic [POS_W-1:0]  pos_q, pos_n;
	logic [POS_W-1:0]  begin_q, begin_n;
	logic              err_q, err_n;

	logic              take;
	logic [POS_W-1:0]  pos_inc;
	logic [POS_W-1:0]  len_tok;
	logic              flush;
	logic              single;
	logic              idle_scan;
	dtt_result_t       flush_res;
	dtt_result_t       single_res;
	tok_kind_t         pkind;

	assign take        = valid_s1 && room;
	assign chars.ready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.valid && chars.ready) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			char_s1 <= chars.char_code;
			eot_s1  <= chars.end_of_text;
		end
	end

	always_comb begin
		pos_inc = (pos_q < POS_W'(POS_MAX)) ? pos_q + 1'b1 : pos_q;
		len_tok = (pos_q >= begin_q) ? pos_q - begin_q : '0;
		pkind   = punct_kind(char_s1);

		flush_res.kind   = (phase_q == PH_WORD) ? TK_WORD : TK_NUMBER;
		flush_res.start  = OFFS_W'(begin_q);
		flush_res.length = OFFS_W'(len_tok);
		flush_res.error  = ER_NONE;
		flush_res.last   = 1'b0;

		single_res.kind   = TK_EOS;
		single_res.start  = OFFS_W'(pos_q);
		single_res.length = '0;
		single_res.error  = ER_NONE;
		single_res.last   = 1'b1;

		phase_n   = phase_q;
		pos_n     = pos_q;
		begin_n   = begin_q;
		err_n     = err_q;
		flush     = 1'b0;
		single    = 1'b0;
		idle_scan = 1'b0;

		if (eot_s1) begin
			single = 1'b1;
			if (!err_q && phase_q == PH_STR) begin
				single_res.error = ER_EOT_STR;
			end else if (!err_q && phase_q != PH_IDLE) begin
				flush = 1'b1;
			end
			phase_n = PH_IDLE;
			pos_n   = '0;
			begin_n = '0;
			err_n   = 1'b0;
		end else if (!err_q) begin
			pos_n = pos_inc;
			case (phase_q)
				PH_WORD: begin
					if (!(is_letter(char_s1) || is_digit(char_s1) || char_s1 == CH_UNDER)) begin
						flush     = 1'b1;
						idle_scan = 1'b1;
					end
				end
				PH_INT, PH_FRAC: begin
					if (is_digit(char_s1)) begin
						// digits extend the number in place
					end else if (char_s1 == CH_DOT && phase_q == PH_INT) begin
						phase_n = PH_FRAC;
					end else if (char_s1 == CH_LOW_E || char_s1 == CH_UP_E) begin
						phase_n = PH_EXPS;
					end else begin
						flush     = 1'b1;
						idle_scan = 1'b1;
					end
				end
				PH_EXPS: begin
					if (is_digit(char_s1) || char_s1 == CH_PLUS || char_s1 == CH_MINUS) begin
						phase_n = PH_EXPD;
					end else begin
						flush     = 1'b1;
						idle_scan = 1'b1;
					end
				end
				PH_EXPD: begin
					if (!is_digit(char_s1)) begin
						flush     = 1'b1;
						idle_scan = 1'b1;
					end
				end
				PH_STR: begin
					if (char_s1 == CH_QUOTE) begin
						single            = 1'b1;
						single_res.kind   = TK_STRING;
						single_res.start  = OFFS_W'(begin_q);
						single_res.length = OFFS_W'(len_tok);
						phase_n           = PH_IDLE;
					end else if (char_s1 == CH_CR || char_s1 == CH_LF) begin
						single           = 1'b1;
						single_res.error = ER_EOL_STR;
						phase_n          = PH_IDLE;
						err_n            = 1'b1;
					end
				end
				default: begin
					idle_scan = 1'b1;
				end
			endcase

			// Between tokens: the character opens a token, is one, or is skipped.
			if (idle_scan) begin
				phase_n = PH_IDLE;
				if (is_space(char_s1)) begin
					// whitespace gives nothing
				end else if (pkind != TK_EOS) begin
					single            = 1'b1;
					single_res.kind   = pkind;
					single_res.length = OFFS_W'(1);
				end else if (is_letter(char_s1)) begin
					phase_n = PH_WORD;
					begin_n = pos_q;
				end else if (is_digit(char_s1) || char_s1 == CH_PLUS || char_s1 == CH_MINUS) begin
					phase_n = PH_INT;
					begin_n = pos_q;
				end else if (char_s1 == CH_QUOTE) begin
					phase_n = PH_STR;
					begin_n = pos_inc;
				end else begin
					single           = 1'b1;
					single_res.error = ER_UNKNOWN;
					err_n            = 1'b1;
				end
			end
		end

		push.count  = take ? 2'({1'b0, flush} + {1'b0, single}) : 2'd0;
		push.first  = flush ? flush_res : single_res;
		push.second = single_res;
		if (flush && !single) begin
			push.first.last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			pos_q   <= '0;
			begin_q <= '0;
			err_q   <= 1'b0;
		end else if (take) begin
			phase_q <= phase_n;
			pos_q   <= pos_n;
			begin_q <= begin_n;
			err_q   <= err_n;
		end
	end

endmodule

/* rtl/dtt_outq.sv */
// ----------------------------------------------------------------------------
// dtt_outq: result queue of the description text tokenizer
// Four-entry queue that takes up to two result words a cycle while it signals
// room, and hands one a cycle to the token channel while that channel is ready.
// ----------------------------------------------------------------------------
module dtt_outq
	import dtt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  dtt_push_t   push,
	output logic        room,
	dtt_token_if.source tokens
);

	localparam int DEPTH = 4;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	dtt_result_t        mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_q;
	logic [PTR_W-1:0]   rd_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               pop;
	logic [PTR_W-1:0]   wr_next;
	dtt_result_t        head;

	// Room for a whole character's worth of results, judged on registered state only.
	assign room    = cnt_q <= CNT_W'(DEPTH - 2);
	assign pop     = tokens.valid && tokens.ready;
	assign wr_next = wr_q + 1'b1;
	assign head    = mem_q[rd_q];

	assign tokens.valid        = cnt_q != '0;
	assign tokens.token_kind   = head.kind;
	assign tokens.token_start  = head.start;
	assign tokens.token_length = head.length;
	assign tokens.error_code   = head.error;
	assign tokens.last         = head.last;

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wr_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			mem_q[wr_next] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + PTR_W'(push.count);
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + CNT_W'(push.count) - CNT_W'(pop);
		end
	end

endmodule

/* rtl/description_text_tokenizer.sv */
// ----------------------------------------------------------------------------
// description_text_tokenizer: streaming tokenizer for a description language
// Top level: character channel in, token channel out.
// ----------------------------------------------------------------------------
// One character word is accepted per cycle unless the input stalls. A
// character that closes a word or number and is itself a token or an error
// yields two result words, which leave the token channel one at a time; the
// character register keeps its word, and the input stalls once that register
// is full, whenever the four-entry result queue has fewer than two free
// places. A result passes through the character register and then the result
// queue before it leaves. Positions saturate at min(MAX_TEXT - 1, 65535), and
// an end-of-text word returns the scan to idle with all positions at zero.
module description_text_tokenizer
	import dtt_pkg::*;
#(
	parameter int MAX_TEXT = 65536
) (
	input logic         clk,
	input logic         arst_n,
	dtt_char_if.sink    chars,
	dtt_token_if.source tokens
);

	dtt_push_t push;
	logic      room;

	dtt_scan #(
		.MAX_TEXT(MAX_TEXT)
	) u_scan (
		.clk   (clk),
		.arst_n(arst_n),
		.chars (chars),
		.room  (room),
		.push  (push)
	);

	dtt_outq u_outq (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.room  (room),
		.tokens(tokens)
	);

endmodule

/* rtl/dtt_checker.sv */
// ----------------------------------------------------------------------------
// dtt_checker: port-level checks of the description text tokenizer
// Watches the token channel and checks handshake and result word rules.
// ----------------------------------------------------------------------------
module dtt_checker
	import dtt_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_ready,
	input logic [KIND_W-1:0] token_kind,
	input logic [OFFS_W-1:0] token_start,
	input logic [OFFS_W-1:0] token_length,
	input logic [ERR_W-1:0]  error_code,
	input logic              last
);

	logic is_punct;

	assign is_punct = (token_kind == TK_LBRACE) || (token_kind == TK_RBRACE)
		|| (token_kind == TK_LPAREN) || (token_kind == TK_RPAREN)
		|| (token_kind == TK_SEMI) || (token_kind == TK_COMMA)
		|| (token_kind == TK_EQUALS) || (token_kind == TK_SLASH);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word withdrawn before it was taken");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(token_kind) && $stable(token_start)
			&& $stable(token_length) && $stable(error_code) && $stable(last))
		else $error("stalled result word changed");

	// An error always ends the results of its character and carries no text.
	a_error_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_code != ER_NONE |-> token_kind == TK_EOS
			&& token_length == '0 && last)
		else $error("malformed error result");

	a_punct_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_punct |-> token_length == OFFS_W'(1) && error_code == ER_NONE)
		else $error("single-character token with wrong length");

endmodule

bind description_text_tokenizer dtt_checker u_dtt_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (tokens.valid),
	.out_ready   (tokens.ready),
	.token_kind  (tokens.token_kind),
	.token_start (tokens.token_start),
	.token_length(tokens.token_length),
	.error_code  (tokens.error_code),
	.last        (tokens.last)
);
